/* src/scaled_glyph_pixel_generator_macros.svh */
// assertion macros for the scaled glyph pixel generator
// no dependencies; included by modules that carry assertions
`ifndef SCALED_GLYPH_PIXEL_GENERATOR_MACROS_SVH
`define SCALED_GLYPH_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGPG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgpg assertion failed");

// next-cycle implication, disabled during reset
`define SGPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgpg assertion failed");

`endif

/* src/sgpg_pkg.sv */
// package for the scaled glyph pixel generator: config struct, register
// indexes, character codes, glyph table and small helper functions; no dependencies
package sgpg_pkg;

  localparam int PANEL_WIDTH_DEF  = 320;
  localparam int PANEL_HEIGHT_DEF = 240;
  localparam int MAX_SCALE_DEF    = 3;

  localparam int CODE_W   = 8;
  localparam int COORD_W  = 11;
  localparam int PIX_W    = 5;
  localparam int COLOR_W  = 16;
  localparam int SCREEN_W = 10;
  localparam int SCALE_W  = 3;
  localparam int GIDX_W   = 6;
  localparam int NUM_GLYPHS = 44;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  typedef struct packed {
    logic                 display_ready;
    logic [SCALE_W-1:0]   scale_factor;
    logic [COLOR_W-1:0]   foreground_color;
    logic [COLOR_W-1:0]   background_color;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_DISPLAY_READY = 2'd0,
    REG_SCALE_FACTOR  = 2'd1,
    REG_FG_COLOR      = 2'd2,
    REG_BG_COLOR      = 2'd3
  } reg_idx_t;

  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CH_CASE    = 8'h20;
  localparam logic [CODE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CODE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CODE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CODE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CODE_W-1:0] CH_COLON   = 8'h3A;
  localparam logic [CODE_W-1:0] CH_PERIOD  = 8'h2E;
  localparam logic [CODE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CODE_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [CODE_W-1:0] CH_BANG    = 8'h21;
  localparam logic [CODE_W-1:0] CH_SLASH   = 8'h2F;

  localparam logic [GIDX_W-1:0] GLYPH_LETTER0 = 6'd10;
  localparam logic [GIDX_W-1:0] GLYPH_SPACE   = 6'd36;
  localparam logic [GIDX_W-1:0] GLYPH_COLON   = 6'd37;
  localparam logic [GIDX_W-1:0] GLYPH_PERIOD  = 6'd38;
  localparam logic [GIDX_W-1:0] GLYPH_COMMA   = 6'd39;
  localparam logic [GIDX_W-1:0] GLYPH_DASH    = 6'd40;
  localparam logic [GIDX_W-1:0] GLYPH_BANG    = 6'd41;
  localparam logic [GIDX_W-1:0] GLYPH_SLASH   = 6'd42;
  localparam logic [GIDX_W-1:0] GLYPH_QUERY   = 6'd43;

  // digits, letters, then space : . , - ! / ?
  localparam logic [0:NUM_GLYPHS-1][0:4][7:0] FONT = {
    {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    {8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, {8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, {8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    {8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    {8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, {8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    {8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, {8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, {8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    {8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, {8'h00, 8'h80, 8'h60, 8'h00, 8'h00},
    {8'h08, 8'h08, 8'h08, 8'h08, 8'h08}, {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
    {8'h20, 8'h10, 8'h08, 8'h04, 8'h02}, {8'h02, 8'h01, 8'h51, 8'h09, 8'h06}
  };

  function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code_in);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] diff;
    logic [GIDX_W-1:0] idx;
    code = code_in;
    if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
      code = code - CH_CASE;
    end
    if (code >= CH_ZERO && code <= CH_NINE) begin
      diff = code - CH_ZERO;
      idx  = GIDX_W'(diff[3:0]);
    end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
      diff = code - CH_UPPER_A;
      idx  = GLYPH_LETTER0 + GIDX_W'(diff[4:0]);
    end else begin
      diff = '0;
      case (code)
        CH_SPACE:  idx = GLYPH_SPACE;
        CH_COLON:  idx = GLYPH_COLON;
        CH_PERIOD: idx = GLYPH_PERIOD;
        CH_COMMA:  idx = GLYPH_COMMA;
        CH_DASH:   idx = GLYPH_DASH;
        CH_BANG:   idx = GLYPH_BANG;
        CH_SLASH:  idx = GLYPH_SLASH;
        default:   idx = GLYPH_QUERY;
      endcase
    end
    return idx;
  endfunction

  // pixel position over scale for scales 1 to 4; thirds by multiply and shift
  function automatic logic [PIX_W-1:0] scale_div(input logic [PIX_W-1:0] v,
                                                  input logic [SCALE_W-1:0] s);
    logic [8:0] prod;
    logic [PIX_W-1:0] q;
    prod = 9'(v) * 9'd11;
    case (s)
      3'd1:    q = v;
      3'd2:    q = v >> 1;
      3'd3:    q = PIX_W'(prod[8:5]);
      3'd4:    q = v >> 2;
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

/* src/sgpg_regs.sv */
// apb-style configuration registers of the scaled glyph pixel generator
// depends on sgpg_pkg for the config struct and register indexes
module sgpg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sgpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [sgpg_pkg::DATA_W-1:0]   pwdata,
  output logic [sgpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output sgpg_pkg::cfg_t                cfg
);

  sgpg_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = sgpg_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_ready    <= 1'b0;
      cfg.scale_factor     <= 3'd1;
      cfg.foreground_color <= 16'hFFFF;
      cfg.background_color <= 16'h0000;
    end else if (wr) begin
      case (idx)
        sgpg_pkg::REG_DISPLAY_READY: cfg.display_ready    <= pwdata[0];
        sgpg_pkg::REG_SCALE_FACTOR:  cfg.scale_factor     <= pwdata[2:0];
        sgpg_pkg::REG_FG_COLOR:      cfg.foreground_color <= pwdata[15:0];
        sgpg_pkg::REG_BG_COLOR:      cfg.background_color <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sgpg_pkg::REG_DISPLAY_READY: prdata = 32'(cfg.display_ready);
      sgpg_pkg::REG_SCALE_FACTOR:  prdata = 32'(cfg.scale_factor);
      sgpg_pkg::REG_FG_COLOR:      prdata = 32'(cfg.foreground_color);
      sgpg_pkg::REG_BG_COLOR:      prdata = 32'(cfg.background_color);
      default:                     prdata = '0;
    endcase
  end

endmodule

/* src/scaled_glyph_pixel_generator.sv */
// top level of the scaled glyph pixel generator: three-stage pixel pipeline
// depends on sgpg_pkg, sgpg_regs and scaled_glyph_pixel_generator_macros.svh
//
// one input item on the s_ stream asks for one pixel of a 6x8 character cell
// scaled by scale_factor; one result item leaves on the m_ stream for each
// input item, in order. m_tuser is the drawn flag; a suppressed pixel comes
// out with drawn low and all tdata fields zero.
// an accepted item passes the three register stages (glyph decode, bound
// check and cell position, glyph lookup and color select) in order, each
// with its own valid bit; m_tdata and m_tuser come straight from stage 3.
// throughput is one item per cycle while m_tready stays high.
// when the receiver holds m_tready low, the output stage keeps its item and
// the stages behind it keep filling; s_tready falls only once all three
// stages hold items, so nothing is lost or repeated.
// registers sit on the apb-style port: display_ready at 0x0, scale_factor at
// 0x4, foreground_color at 0x8, background_color at 0xC; write them only
// while no item is in flight.
// synchronous reset empties the pipeline and restores register defaults
// (not ready, scale 1, white foreground, black background).
`include "scaled_glyph_pixel_generator_macros.svh"

module scaled_glyph_pixel_generator #(
  parameter int PANEL_WIDTH  = sgpg_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = sgpg_pkg::PANEL_HEIGHT_DEF,
  parameter int MAX_SCALE    = sgpg_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // char_code, origin_x, origin_y, pixel_col, pixel_row
  input  logic [sgpg_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pixel_color, screen_x, screen_y, zero pad
  output logic [sgpg_pkg::OUT_DATA_W-1:0]   m_tdata,
  // drawn
  output logic                              m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sgpg_pkg::ADDR_W-1:0]       paddr,
  input  logic [sgpg_pkg::DATA_W-1:0]       pwdata,
  output logic [sgpg_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  sgpg_pkg::cfg_t cfg;

  sgpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = ~v3 | m_tready;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: glyph index and capture
  logic [sgpg_pkg::GIDX_W-1:0]  gidx1;
  logic [sgpg_pkg::COORD_W-1:0] ox1, oy1;
  logic [sgpg_pkg::PIX_W-1:0]   pc1, pr1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      gidx1 <= sgpg_pkg::glyph_index(s_tdata[7:0]);
      ox1   <= s_tdata[18:8];
      oy1   <= s_tdata[29:19];
      pc1   <= s_tdata[34:30];
      pr1   <= s_tdata[39:35];
    end
  end

  // stage 2: checks, cell position, screen coordinates
  logic [5:0]  cell_w, cell_h;
  logic [11:0] right_edge, bottom_edge;
  logic        scale_ok, bounds_ok, pix_ok, ok_next;
  logic [sgpg_pkg::PIX_W-1:0] gcol_full, grow_full;
  logic [sgpg_pkg::SCREEN_W-1:0] sx_sum, sy_sum;

  logic                             ok2, in_col2;
  logic [sgpg_pkg::GIDX_W-1:0]      gidx2;
  logic [2:0]                       gcol2, grow2;
  logic [sgpg_pkg::SCREEN_W-1:0]    sx2, sy2;

  always_comb begin
    cell_w      = 6'(cfg.scale_factor) * 6'd6;
    cell_h      = {cfg.scale_factor, 3'b000};
    right_edge  = 12'(ox1[9:0]) + 12'(cell_w);
    bottom_edge = 12'(oy1[9:0]) + 12'(cell_h);
    scale_ok    = (cfg.scale_factor != '0) &&
                  ({1'b0, cfg.scale_factor} <= 4'(MAX_SCALE));
    bounds_ok   = ~ox1[10] && ~oy1[10] &&
                  (right_edge <= 12'(PANEL_WIDTH)) &&
                  (bottom_edge <= 12'(PANEL_HEIGHT));
    pix_ok      = (6'(pc1) < cell_w) && (6'(pr1) < cell_h);
    ok_next     = cfg.display_ready & scale_ok & bounds_ok & pix_ok;
    gcol_full   = sgpg_pkg::scale_div(pc1, cfg.scale_factor);
    grow_full   = sgpg_pkg::scale_div(pr1, cfg.scale_factor);
    sx_sum      = ox1[9:0] + 10'(pc1);
    sy_sum      = oy1[9:0] + 10'(pr1);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ok2     <= ok_next;
      in_col2 <= gcol_full < 5'd5;
      gidx2   <= gidx1;
      gcol2   <= gcol_full[2:0];
      grow2   <= grow_full[2:0];
      sx2     <= ok_next ? sx_sum : '0;
      sy2     <= ok_next ? sy_sum : '0;
    end
  end

  // stage 3: glyph bit and color
  logic [7:0]                   col_byte;
  logic                         bit_set;
  logic [sgpg_pkg::COLOR_W-1:0] color;

  logic [sgpg_pkg::COLOR_W-1:0]  color3;
  logic [sgpg_pkg::SCREEN_W-1:0] sx3, sy3;
  logic                          drawn3;

  always_comb begin
    col_byte = '0;
    if (in_col2 && gidx2 < 6'(sgpg_pkg::NUM_GLYPHS)) begin
      col_byte = sgpg_pkg::FONT[gidx2][gcol2];
    end
    bit_set = col_byte[grow2];
    color   = bit_set ? cfg.foreground_color : cfg.background_color;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      color3 <= ok2 ? {color[7:0], color[15:8]} : '0;
      sx3    <= sx2;
      sy3    <= sy2;
      drawn3 <= ok2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {4'b0000, sy3, sx3, color3};
  assign m_tuser  = drawn3;

  `SGPG_ASSERT_NOW(a_suppressed_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `SGPG_ASSERT_NOW(a_drawn_needs_ready, clk, rst, m_tvalid && m_tuser, cfg.display_ready)
  `SGPG_ASSERT_NOW(a_backpressure_full, clk, rst, !s_tready, v1 && v2 && v3 && !m_tready)
  `SGPG_ASSERT_NEXT(a_stage_advance, clk, rst, v2 && rdy3, v3)

endmodule
